@@ src/mrfd_pkg.sv @@
// Shared types and constants for the meter reply frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package mrfd_pkg;

  localparam logic [7:0] START_BYTE  = 8'h68;
  localparam logic [7:0] BYTE_OFFSET = 8'h33;
  localparam logic [7:0] CTRL_REPLY  = 8'h81;

  localparam logic [7:0] ID_HI_ENERGY_A = 8'h90;
  localparam logic [7:0] ID_HI_ENERGY_B = 8'h91;
  localparam logic [7:0] ID_HI_INST     = 8'hB6;

  localparam logic [1:0] STATUS_VALUE     = 2'd0;
  localparam logic [1:0] STATUS_UNDECODED = 2'd1;
  localparam logic [1:0] STATUS_HEADER    = 2'd2;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd3;

  typedef enum logic [1:0] {
    KIND_HDR_ERR = 2'd0,
    KIND_SUM_ERR = 2'd1,
    KIND_FRAME   = 2'd2
  } frame_kind_t;

  // One finished frame as handed from the parser to the decoder.
  typedef struct packed {
    frame_kind_t  kind;
    logic         reply;
    logic [15:0]  id;
    logic [31:0]  value;
  } frame_rec_t;

endpackage

@@ src/mrfd_channels.sv @@
// Valid/ready channel interfaces for received bytes, results and configuration.
// No dependencies.
`timescale 1ns / 1ps

interface mrfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         point_index;
  logic signed [28:0] scaled_value;
  logic [2:0]         decimals;
  logic [15:0]        data_id;
  modport source (output valid, output status, output point_index, output scaled_value,
                  output decimals, output data_id, input ready);
  modport sink   (input valid, input status, input point_index, input scaled_value,
                  input decimals, input data_id, output ready);
endinterface

interface mrfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] meter_address;
  modport source (output valid, output meter_address, input ready);
  modport sink   (input valid, input meter_address, output ready);
endinterface

@@ src/meter_reply_frame_decoder_unit.sv @@
// Meter reply frame decoder: one received byte per cycle. A frame's result is registered
// in the queue, then s1 and output stages, after the end byte or a bad header's 12th byte.
// Bytes are taken every cycle while the frame queue has room; decoding stalls on its own.
// Synchronous active-high reset returns to hunting and clears the meter address.
// Depends on mrfd_pkg, mrfd_channels, mrfd_front, mrfd_queue, mrfd_back.
`timescale 1ns / 1ps

module meter_reply_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  mrfd_cfg_if.sink         cfg,
  mrfd_rx_if.sink          rx,
  mrfd_result_if.source    result
);
  import mrfd_pkg::*;

  logic [47:0] meter_address;
  logic        q_full;
  logic        byte_fire;
  logic        push;
  frame_rec_t  push_rec;
  logic        pop;
  logic        head_valid;
  frame_rec_t  head_rec;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meter_address <= 48'd0;
    end else if (cfg.valid) begin
      meter_address <= cfg.meter_address;
    end
  end

  assign rx.ready  = !q_full;
  assign byte_fire = rx.valid && !q_full;

  mrfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_fire     (byte_fire),
    .rx_byte       (rx.rx_byte),
    .meter_address (meter_address),
    .push          (push),
    .rec           (push_rec)
  );

  mrfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  mrfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (head_valid),
    .rec          (head_rec),
    .rec_pop      (pop),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .status       (result.status),
    .point_index  (result.point_index),
    .scaled_value (result.scaled_value),
    .decimals     (result.decimals),
    .data_id      (result.data_id)
  );

endmodule

@@ src/mrfd_front.sv @@
// Frame parser: hunts for the start byte, checks header, sums and captures fields.
// Depends on mrfd_pkg.
`timescale 1ns / 1ps

module mrfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_fire,
  input  logic [7:0]          rx_byte,
  input  logic [47:0]         meter_address,
  output logic                push,
  output mrfd_pkg::frame_rec_t rec
);
  import mrfd_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT       = 5'b00001,
    PH_HEADER     = 5'b00010,
    PH_HEADER_BAD = 5'b00100,
    PH_BODY       = 5'b01000,
    PH_END        = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [8:0]  pos, pos_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  len, len_next;
  logic        reply, reply_next;
  logic [15:0] id, id_next;
  logic [31:0] value, value_next;
  logic        sum_ok, sum_ok_next;

  logic [8:0]  pos_inc;
  logic [8:0]  body_idx;
  logic [7:0]  addr_byte;
  logic [7:0]  stripped;
  logic        hdr_ok;

  assign pos_inc  = pos + 9'd1;
  assign body_idx = pos_inc - 9'd10;
  assign stripped = rx_byte - BYTE_OFFSET;

  always_comb begin
    unique case (pos[2:0])
      3'd0: addr_byte = meter_address[7:0];
      3'd1: addr_byte = meter_address[15:8];
      3'd2: addr_byte = meter_address[23:16];
      3'd3: addr_byte = meter_address[31:24];
      3'd4: addr_byte = meter_address[39:32];
      3'd5: addr_byte = meter_address[47:40];
      default: addr_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (pos_inc <= 9'd6) begin
      hdr_ok = (rx_byte == addr_byte);
    end else if (pos_inc == 9'd7) begin
      hdr_ok = (rx_byte == START_BYTE);
    end else begin
      hdr_ok = 1'b1;
    end
  end

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    sum_next    = sum;
    len_next    = len;
    reply_next  = reply;
    id_next     = id;
    value_next  = value;
    sum_ok_next = sum_ok;
    push        = 1'b0;
    rec.kind    = KIND_FRAME;
    rec.reply   = reply;
    rec.id      = id;
    rec.value   = value;
    if (byte_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) begin
            phase_next  = PH_HEADER;
            pos_next    = 9'd0;
            sum_next    = START_BYTE;
            len_next    = 8'd0;
            reply_next  = 1'b0;
            id_next     = 16'd0;
            value_next  = 32'd0;
            sum_ok_next = 1'b0;
          end
        end
        PH_HEADER: begin
          pos_next = pos_inc;
          if (!hdr_ok) begin
            phase_next = PH_HEADER_BAD;
          end else begin
            sum_next = sum + rx_byte;
            if (pos_inc == 9'd8) begin
              reply_next = (rx_byte == CTRL_REPLY);
            end else if (pos_inc == 9'd9) begin
              len_next   = rx_byte;
              phase_next = PH_BODY;
            end
          end
        end
        PH_HEADER_BAD: begin
          pos_next = pos_inc;
          if (pos_inc >= 9'd11) begin
            push       = 1'b1;
            rec.kind   = KIND_HDR_ERR;
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          pos_next = pos_inc;
          if (body_idx >= {1'b0, len}) begin
            sum_ok_next = (rx_byte == sum);
            phase_next  = PH_END;
          end else begin
            sum_next = sum + rx_byte;
            unique case (body_idx)
              9'd0: id_next[7:0] = stripped;
              9'd1: id_next[15:8] = stripped;
              9'd2: value_next[7:0] = stripped;
              9'd3: value_next[15:8] = stripped;
              9'd4: value_next[23:16] = stripped;
              9'd5: value_next[31:24] = stripped;
              default: ;
            endcase
          end
        end
        PH_END: begin
          push       = 1'b1;
          rec.kind   = sum_ok ? KIND_FRAME : KIND_SUM_ERR;
          phase_next = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      pos    <= 9'd0;
      sum    <= 8'd0;
      len    <= 8'd0;
      reply  <= 1'b0;
      id     <= 16'd0;
      value  <= 32'd0;
      sum_ok <= 1'b0;
    end else begin
      phase  <= phase_next;
      pos    <= pos_next;
      sum    <= sum_next;
      len    <= len_next;
      reply  <= reply_next;
      id     <= id_next;
      value  <= value_next;
      sum_ok <= sum_ok_next;
    end
  end

endmodule

@@ src/mrfd_queue.sv @@
// Short queue of finished frame records between parser and decoder.
// Depends on mrfd_pkg.
`timescale 1ns / 1ps

module mrfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mrfd_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output mrfd_pkg::frame_rec_t head_rec
);
  import mrfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/mrfd_back.sv @@
// Decoder: classifies identifiers, weighs BCD digits, signs and registers the result.
// Depends on mrfd_pkg.
`timescale 1ns / 1ps

module mrfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  mrfd_pkg::frame_rec_t rec,
  output logic                 rec_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           status,
  output logic [4:0]           point_index,
  output logic signed [28:0]   scaled_value,
  output logic [2:0]           decimals,
  output logic [15:0]          data_id
);
  import mrfd_pkg::*;

  // classification stage
  logic        s1_valid;
  logic [1:0]  s1_status;
  logic [4:0]  s1_point;
  logic [2:0]  s1_dec;
  logic        s1_neg;
  logic [15:0] s1_id;
  logic [7:0]  s1_pair [4];

  logic        s1_take;
  logic        s2_take;

  logic [1:0]  c_status;
  logic [4:0]  c_point;
  logic [2:0]  c_dec;
  logic        c_neg;
  logic [15:0] c_id;
  logic [31:0] c_digits;
  logic [7:0]  c_pair [4];
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [4:0]  lo_sel;

  logic [27:0] mag;
  logic [28:0] signed_mag;

  assign s2_take = !res_valid || res_ready;
  assign s1_take = !s1_valid || s2_take;
  assign rec_pop = rec_valid && s1_take;

  assign lo     = rec.id[7:0];
  assign hi     = rec.id[15:8];
  assign lo_sel = {3'b000, lo[1:0]};

  always_comb begin
    c_status = STATUS_VALUE;
    c_point  = 5'd0;
    c_dec    = 3'd0;
    c_neg    = 1'b0;
    c_digits = 32'd0;
    c_id     = rec.id;
    unique case (rec.kind)
      KIND_HDR_ERR: begin
        c_status = STATUS_HEADER;
        c_id     = 16'd0;
      end
      KIND_SUM_ERR: begin
        c_status = STATUS_CHECKSUM;
        c_id     = 16'd0;
      end
      KIND_FRAME: begin
        priority if (!rec.reply) begin
          c_status = STATUS_UNDECODED;
        end else if ((hi == ID_HI_ENERGY_A || hi == ID_HI_ENERGY_B) &&
                     (lo == 8'h10 || lo == 8'h20)) begin
          c_point  = (lo == 8'h10) ? {4'd0, hi[0]} : (5'd24 + {4'd0, hi[0]});
          c_digits = rec.value;
          c_dec    = 3'd2;
        end else if (hi == ID_HI_INST && lo >= 8'h11 && lo <= 8'h13) begin
          c_point  = 5'd1 + lo_sel;
          c_digits = {16'd0, rec.value[15:0]};
        end else if (hi == ID_HI_INST && lo >= 8'h21 && lo <= 8'h23) begin
          c_point  = 5'd4 + lo_sel;
          c_digits = {16'd0, rec.value[15:0]};
          c_dec    = 3'd2;
        end else if (hi == ID_HI_INST && lo >= 8'h30 && lo <= 8'h33) begin
          c_point  = 5'd8 + lo_sel;
          c_digits = {9'd0, rec.value[22:0]};
          c_neg    = rec.value[23];
          c_dec    = 3'd4;
        end else if (hi == ID_HI_INST && lo >= 8'h40 && lo <= 8'h43) begin
          c_point  = 5'd14 + lo_sel;
          c_digits = {17'd0, rec.value[14:0]};
          c_neg    = rec.value[15];
          c_dec    = 3'd2;
        end else if (hi == ID_HI_INST && lo >= 8'h50 && lo <= 8'h53) begin
          c_point  = 5'd20 + lo_sel;
          c_digits = {16'd0, rec.value[15:0]};
          c_dec    = 3'd3;
        end else begin
          c_status = STATUS_UNDECODED;
        end
      end
      default: begin
        c_status = STATUS_UNDECODED;
      end
    endcase
  end

  // two nibbles per byte weigh to at most 165
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_pair[k] = {4'd0, c_digits[8*k +: 4]} + ({4'd0, c_digits[8*k+4 +: 4]} * 8'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_status <= c_status;
      s1_point  <= c_point;
      s1_dec    <= c_dec;
      s1_neg    <= c_neg;
      s1_id     <= c_id;
      for (int k = 0; k < 4; k++) begin
        s1_pair[k] <= c_pair[k];
      end
    end
  end

  assign mag = {20'd0, s1_pair[0]} + ({20'd0, s1_pair[1]} * 28'd100) +
               ({20'd0, s1_pair[2]} * 28'd10000) + ({20'd0, s1_pair[3]} * 28'd1000000);
  assign signed_mag = s1_neg ? (29'd0 - {1'b0, mag}) : {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_take) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      status       <= s1_status;
      point_index  <= s1_point;
      scaled_value <= signed_mag;
      decimals     <= s1_dec;
      data_id      <= s1_id;
    end
  end

endmodule

@@ src/mrfd_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on mrfd_pkg and meter_reply_frame_decoder_unit.
`timescale 1ns / 1ps

module mrfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         status,
  input logic [4:0]         point_index,
  input logic signed [28:0] scaled_value,
  input logic [2:0]         decimals,
  input logic [15:0]        data_id
);
  import mrfd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(data_id) &&
      $stable(scaled_value) && $stable(point_index) && $stable(decimals))
    else $error("result changed while stalled");

  a_undecoded_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != STATUS_VALUE |-> point_index == 5'd0 && scaled_value == 29'sd0 &&
      decimals == 3'd0)
    else $error("undecoded result carries value fields");

  a_error_no_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == STATUS_HEADER || status == STATUS_CHECKSUM) |-> data_id == 16'd0)
    else $error("error result carries identifier");

  a_decimals: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> decimals == 3'd0 || decimals == 3'd2 || decimals == 3'd3 ||
      decimals == 3'd4)
    else $error("bad decimal scale");

  a_point_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_VALUE |-> point_index <= 5'd25)
    else $error("point index out of range");

endmodule

bind meter_reply_frame_decoder_unit mrfd_checker u_mrfd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .status       (result.status),
  .point_index  (result.point_index),
  .scaled_value (result.scaled_value),
  .decimals     (result.decimals),
  .data_id      (result.data_id)
);
